FILE: hdl/resize_motion_settle_detector_top_assert.svh
// Assertion macros for the resize motion settle detector.
// Used by the top level; needs i_clk and i_rst_n in scope.
`ifndef RESIZE_MOTION_SETTLE_DETECTOR_TOP_ASSERT_SVH
`define RESIZE_MOTION_SETTLE_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication
`define RMSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rmsd assertion failed");

// next-cycle implication
`define RMSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rmsd assertion failed");

`endif

FILE: hdl/rmsd_pkg.sv
// Shared types and constants of the resize motion settle detector.
// No dependencies.
package rmsd_pkg;

    localparam int SQ_W    = 38;  // dw^2 + dh^2
    localparam int ROOT_W  = 19;  // step length
    localparam int NUM_W   = 44;  // dividend of both divisions
    localparam int DEN_W   = 48;  // dt
    localparam int SPEED_W = 24;
    localparam int ACCEL_W = 32;

    localparam logic [15:0] SPEED_SCALE = 16'd62500;
    localparam logic [19:0] ACCEL_SCALE = 20'd1000000;

    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;  // unused code, dropped

    localparam logic [1:0] PH_ACTIVE    = 2'd0;
    localparam logic [1:0] PH_SETTLING  = 2'd1;
    localparam logic [1:0] PH_COMPLETED = 2'd2;

    localparam logic [1:0] REG_VEL_LIMIT   = 2'd0;
    localparam logic [1:0] REG_ACCEL_LIMIT = 2'd1;
    localparam logic [1:0] REG_QUIET       = 2'd2;
    localparam logic [1:0] REG_STEP_THR    = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_FINISH
    } t_state;

endpackage

FILE: hdl/rmsd_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on rmsd_pkg.
module rmsd_sqrt import rmsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_value,
    output t_unit_status      o_status,
    output logic [ROOT_W-1:0] o_root
);
    logic [SQ_W-1:0]   r_val,  n_val;
    logic [ROOT_W+1:0] r_rem,  n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [4:0]        r_cnt,  n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ROOT_W+3:0] w_trem;
    logic [ROOT_W+3:0] w_trial;

    assign w_trem  = {r_rem, r_val[SQ_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};

    always_comb begin
        n_val  = r_val;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_val  = i_value;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = 5'(ROOT_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_val = {r_val[SQ_W-3:0], 2'b00};
            if (w_trem >= w_trial) begin
                n_rem  = (ROOT_W+2)'(w_trem - w_trial);
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_trem[ROOT_W+1:0];
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_root        = r_root;
endmodule

FILE: hdl/rmsd_div.sv
// Restoring divider, one quotient bit per cycle, shared by speed and accel.
// Depends on rmsd_pkg.
module rmsd_div import rmsd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_unit_status     o_status,
    output logic [NUM_W-1:0] o_quot
);
    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [5:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DEN_W:0]   w_sh;

    assign w_sh = {r_rem, r_num[NUM_W-1]};

    always_comb begin
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_num  = i_num;
            n_den  = i_den;
            n_rem  = '0;
            n_cnt  = 6'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // quotient bits shift in where dividend bits leave
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = DEN_W'(w_sh - {1'b0, r_den});
                n_num = {r_num[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh[DEN_W-1:0];
                n_num = {r_num[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_num;
endmodule

FILE: hdl/resize_motion_settle_detector_top.sv
// Resize motion settle detector: sequencer, session state and output register.
// Depends on rmsd_pkg, rmsd_sqrt, rmsd_div and the assertion macro header.
//
// Usage:
// - Slave channel takes one size sample per word: opcode in tuser, width,
//   height and timestamp in tdata. Master channel returns one result word
//   per sample: session number, phase, speed and acceleration.
// - Begin, and an update or end outside a session, open a session: the
//   sequencer goes straight from idle to the finish step, which loads the result register.
// - An update or end inside a session runs a square root and two
//   divisions in sequence before the finish step loads the result
//   register; the shared divider takes most of that time. A step with dt
//   of at most 1 us skips the root and the divisions.
// - o_s_tready is high only while the sequencer is idle.
// - Opcode 3 is accepted and dropped: no result, no change to the session state.
// - The result sits in an output register. A stalled receiver does not
//   block the next sample from being accepted and processed; only the
//   finish step waits until the register is free.
// - Reset (synchronous, active low) closes any session, sets the session
//   counter to 1 and the limit registers to their defaults.
// - Write limit registers through i_cfg_* only while no word is in flight.
`include "resize_motion_settle_detector_top_assert.svh"

module resize_motion_settle_detector_top import rmsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [87:0] i_s_tdata,   // width_sixteenths[17:0], height_sixteenths[35:18],
                                     // time_us[83:36], zero fill
    input  logic [1:0]  i_s_tuser,   // opcode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // session_number[31:0], phase[33:32], speed[57:34],
                                     // accel[89:58], zero fill
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [20:0] i_cfg_wdata
);
    // limit registers
    logic [13:0] r_vel_limit;
    logic [14:0] r_acc_limit;
    logic [20:0] r_quiet;
    logic [8:0]  r_step_thr;

    // session state
    logic        r_in_session;
    logic [31:0] r_sess_cnt;
    logic [31:0] r_cur_sess;
    logic [17:0] r_prev_w;
    logic [17:0] r_prev_h;
    logic [SPEED_W-1:0] r_prev_speed;
    logic [47:0] r_prev_t;
    logic [47:0] r_last_chg;

    // captured sample and work registers
    logic [1:0]  r_op;
    logic [17:0] r_w;
    logic [17:0] r_h;
    logic [47:0] r_t;
    logic        r_open;
    logic [36:0] r_sqw;
    logic [36:0] r_sqh;
    logic [SQ_W-1:0] r_sq;
    logic        r_sig;
    logic        r_tiny;
    logic [SPEED_W-1:0] r_speed;
    logic [ACCEL_W-1:0] r_accel;
    logic        r_calm;

    logic        r_out_valid;
    logic [95:0] r_out_data;

    t_state r_state, n_state;

    // sequencer outputs
    logic w_accept;
    logic w_sqrt_start;
    logic w_div_start;
    logic w_load_out;

    logic [NUM_W-1:0] w_div_num;
    logic [NUM_W-1:0] w_quot;
    logic [ROOT_W-1:0] w_root;
    t_unit_status w_sqrt_st;
    t_unit_status w_div_st;

    logic signed [18:0] w_dw, w_dh;
    logic signed [37:0] w_dw2, w_dh2;
    logic [17:0] w_thr2;
    logic [47:0] w_dt;
    logic [SPEED_W-1:0] w_diff;
    logic [43:0] w_diff_prod;
    logic [34:0] w_step_prod;
    logic [47:0] w_lct_new;
    logic        w_quiet;
    logic        w_slow;
    logic [1:0]  w_phase;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    // step arithmetic
    assign w_dw   = $signed({1'b0, r_w}) - $signed({1'b0, r_prev_w});
    assign w_dh   = $signed({1'b0, r_h}) - $signed({1'b0, r_prev_h});
    assign w_dw2  = w_dw * w_dw;
    assign w_dh2  = w_dh * w_dh;
    assign w_thr2 = r_step_thr * r_step_thr;
    assign w_dt   = r_t - r_prev_t;

    // speed change magnitude; the sign is picked again when accel is stored
    assign w_step_prod = w_root * SPEED_SCALE;
    assign w_diff      = (r_speed < r_prev_speed) ? (r_prev_speed - r_speed)
                                                  : (r_speed - r_prev_speed);
    assign w_diff_prod = w_diff * ACCEL_SCALE;
    assign w_div_num   = (r_state == S_DIV1_GO) ? {9'd0, w_step_prod} : w_diff_prod;

    rmsd_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_sqrt_start),
        .i_value  (r_sq),
        .o_status (w_sqrt_st),
        .o_root   (w_root)
    );

    rmsd_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (w_div_num),
        .i_den    (w_dt),
        .o_status (w_div_st),
        .o_quot   (w_quot)
    );

    // classification at finish
    assign w_lct_new = r_sig ? r_t : r_last_chg;
    assign w_quiet   = (r_t >= w_lct_new) && ((r_t - w_lct_new) >= {27'd0, r_quiet});
    assign w_slow    = r_speed <= {10'd0, r_vel_limit};

    always_comb begin
        if (r_open) begin
            w_phase = PH_ACTIVE;
        end else if (w_slow && r_calm) begin
            w_phase = w_quiet ? PH_COMPLETED : PH_SETTLING;
        end else begin
            w_phase = PH_ACTIVE;
        end
        if (r_op == OP_END) begin
            w_phase = PH_COMPLETED;
        end
    end

    // next state
    always_comb begin
        n_state      = r_state;
        w_sqrt_start = 1'b0;
        w_div_start  = 1'b0;
        w_load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_s_tuser != OP_NONE) begin
                    if (i_s_tuser == OP_BEGIN || !r_in_session) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SQUARE;
                    end
                end
            end
            S_SQUARE: n_state = S_SUM;
            S_SUM: begin
                n_state = S_SQRT_GO;
            end
            S_SQRT_GO: begin
                if (r_tiny) begin
                    n_state = S_FINISH;
                end else begin
                    w_sqrt_start = 1'b1;
                    n_state      = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT: begin
                if (w_sqrt_st.done) begin
                    n_state = S_DIV1_GO;
                end
            end
            S_DIV1_GO: begin
                w_div_start = 1'b1;
                n_state     = S_DIV1_WAIT;
            end
            S_DIV1_WAIT: begin
                if (w_div_st.done) begin
                    n_state = S_DIV2_GO;
                end
            end
            S_DIV2_GO: begin
                w_div_start = 1'b1;
                n_state     = S_DIV2_WAIT;
            end
            S_DIV2_WAIT: begin
                if (w_div_st.done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // wait for the output register to drain
                if (!r_out_valid || i_m_tready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_limit <= 14'd20;
            r_acc_limit <= 15'd80;
            r_quiet     <= 21'd120000;
            r_step_thr  <= 9'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_VEL_LIMIT:   r_vel_limit <= i_cfg_wdata[13:0];
                REG_ACCEL_LIMIT: r_acc_limit <= i_cfg_wdata[14:0];
                REG_QUIET:       r_quiet     <= i_cfg_wdata;
                REG_STEP_THR:    r_step_thr  <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // capture the sample and run the datapath steps
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_s_tuser;
            r_w    <= i_s_tdata[17:0];
            r_h    <= i_s_tdata[35:18];
            r_t    <= i_s_tdata[83:36];
            r_open <= (i_s_tuser == OP_BEGIN) || !r_in_session;
            r_speed <= '0;
            r_accel <= '0;
            r_calm  <= 1'b1;
            r_sig   <= 1'b0;
        end
        if (r_state == S_SQUARE) begin
            r_sqw  <= w_dw2[36:0];
            r_sqh  <= w_dh2[36:0];
            r_tiny <= {1'b0, r_t} <= ({1'b0, r_prev_t} + 49'd1);
        end
        if (r_state == S_SUM) begin
            r_sq  <= {1'b0, r_sqw} + {1'b0, r_sqh};
            r_sig <= ({1'b0, r_sqw} + {1'b0, r_sqh}) >= {20'd0, w_thr2};
        end
        if (r_state == S_DIV1_WAIT && w_div_st.done) begin
            // saturate the speed
            r_speed <= (|w_quot[NUM_W-1:SPEED_W]) ? {SPEED_W{1'b1}} : w_quot[SPEED_W-1:0];
        end
        if (r_state == S_DIV2_WAIT && w_div_st.done) begin
            r_calm <= w_quot <= {29'd0, r_acc_limit};
            if (r_speed >= r_prev_speed) begin
                r_accel <= (w_quot > 44'h0007FFFFFFF) ? 32'h7FFFFFFF : w_quot[31:0];
            end else begin
                r_accel <= (w_quot > 44'h00080000000) ? 32'h80000000 : (32'd0 - w_quot[31:0]);
            end
        end
    end

    // session state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_session <= 1'b0;
            r_sess_cnt   <= 32'd1;
            r_cur_sess   <= '0;
            r_prev_w     <= '0;
            r_prev_h     <= '0;
            r_prev_speed <= '0;
            r_prev_t     <= '0;
            r_last_chg   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_prev_w    <= r_w;
                r_prev_h    <= r_h;
                r_prev_t    <= r_t;
                r_in_session <= (r_op != OP_END);
                if (r_open) begin
                    r_cur_sess   <= r_sess_cnt;
                    r_sess_cnt   <= r_sess_cnt + 32'd1;
                    r_prev_speed <= '0;
                    r_last_chg   <= r_t;
                end else begin
                    r_prev_speed <= r_speed;
                    r_last_chg   <= w_lct_new;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {6'd0,
                           r_open ? 32'd0 : r_accel,
                           r_open ? {SPEED_W{1'b0}} : r_speed,
                           w_phase,
                           r_open ? r_sess_cnt : r_cur_sess};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `RMSD_ASSERT_NOW(a_idle_units_quiet, r_state == S_IDLE, !w_sqrt_st.busy && !w_div_st.busy)
    `RMSD_ASSERT_NOW(a_div_done_in_div, w_div_st.done,
        r_state == S_DIV1_WAIT || r_state == S_DIV2_WAIT)
    `RMSD_ASSERT_NOW(a_phase_legal, o_m_tvalid, o_m_tdata[33:32] <= PH_COMPLETED)
    `RMSD_ASSERT_NEXT(a_accept_leaves_idle, w_accept && i_s_tuser != OP_NONE, r_state != S_IDLE)
endmodule
